// File: rtl/assert_macros.svh
// Assertion macros used by the checker file, pls_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define PLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/pls_pkg.sv
// Package for the positional list store: field widths and command codes.
// No dependencies.
package pls_pkg;

	localparam int CMD_W = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 8;
	localparam int CNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

endpackage

// File: rtl/positional_list_store.sv
// Positional list store: bounded ordered byte list held in a row of shift cells.
// Depends on pls_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  cmd     | in        | cmd_valid / cmd_ready | cmd, position, item_value
//  rsp     | out       | rsp_valid / rsp_ready | ok, read_value, entry_count, is_empty
//
// One command is taken per cycle while no result is stalled; its result passes the input
// register and then the result register before rsp_valid is raised.
// The per-slot select (hold, shift up, shift down, load) sits between the input
// register and the result register, so each command takes one stage of work.
// Reset clears the entry count and empties both registers; slot contents are not
// cleared, since no command can see a slot at or beyond the count.
// A stalled result holds the result register; one more command then waits in
// the input register, and cmd_ready drops until the result is taken.
module positional_list_store #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [pls_pkg::CMD_W-1:0]  cmd,
	input  logic [pls_pkg::POS_W-1:0]  position,
	input  logic [pls_pkg::VAL_W-1:0]  item_value,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       ok,
	output logic [pls_pkg::VAL_W-1:0]  read_value,
	output logic [pls_pkg::CNT_W-1:0]  entry_count,
	output logic                       is_empty
);

	// Count width holds DEPTH itself; address width indexes a slot.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	// Compare width: wide enough for both the position field and the count.
	localparam int PW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;

	// Input register
	logic                       valid_s1;
	pls_pkg::cmd_t              cmd_s1;
	logic [pls_pkg::POS_W-1:0]  pos_s1;
	logic [pls_pkg::VAL_W-1:0]  val_s1;

	// List state
	logic [pls_pkg::VAL_W-1:0]  slots_q [DEPTH];
	logic [pls_pkg::VAL_W-1:0]  slot_d  [DEPTH];
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_d;

	// Result register
	logic                       rsp_valid_q;
	logic                       ok_q;
	logic [pls_pkg::VAL_W-1:0]  rd_q;
	logic [pls_pkg::CNT_W-1:0]  cnt_q;
	logic                       empty_q;

	logic                       advance;
	logic [PW-1:0]              pos_x;
	logic [PW-1:0]              count_x;
	logic [PW-1:0]              ins_pos;
	logic                       do_ins;
	logic                       do_del;
	logic                       do_rd;
	logic                       op_ok;
	logic [pls_pkg::VAL_W-1:0]  rd_d;
	logic [PW-1:0]              count_dx;

	// Result register frees when empty or taken; input register frees when it advances.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= pls_pkg::cmd_t'(cmd);
			pos_s1 <= position;
			val_s1 <= item_value;
		end
	end

	// Decode and range checks
	assign pos_x   = PW'(pos_s1);
	assign count_x = PW'(count_q);

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_rd   = 1'b0;
		ins_pos = pos_x;
		unique case (cmd_s1)
			pls_pkg::CMD_APPEND: begin
				ins_pos = count_x;
				do_ins  = count_x < PW'(DEPTH);
			end
			pls_pkg::CMD_INSERT: begin
				do_ins = (count_x < PW'(DEPTH)) && (pos_x <= count_x);
			end
			pls_pkg::CMD_DELETE: begin
				do_del = pos_x < count_x;
			end
			pls_pkg::CMD_READ: begin
				do_rd = pos_x < count_x;
			end
			default: begin
				do_rd = 1'b0;
			end
		endcase
	end

	assign op_ok = do_ins || do_del || do_rd;

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_del) begin
			count_d = count_q - CW'(1);
		end
	end

	// Read mux; the address is in range whenever do_rd is set.
	assign rd_d     = do_rd ? slots_q[pos_x[AW-1:0]] : '0;
	assign count_dx = PW'(count_d);

	// Per-slot select: each cell compares its own index with the position.
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic [pls_pkg::VAL_W-1:0] up_src;
		logic [pls_pkg::VAL_W-1:0] dn_src;

		if (i > 0) begin : g_up
			assign up_src = slots_q[i-1];
		end else begin : g_up0
			assign up_src = slots_q[i];
		end

		if (i < DEPTH - 1) begin : g_dn
			assign dn_src = slots_q[i+1];
		end else begin : g_dnl
			assign dn_src = slots_q[i];
		end

		always_comb begin
			slot_d[i] = slots_q[i];
			if (do_ins) begin
				if (PW'(i) == ins_pos) begin
					slot_d[i] = val_s1;
				end else if (PW'(i) > ins_pos) begin
					slot_d[i] = up_src;
				end
			end else if (do_del) begin
				if (PW'(i) >= pos_x) begin
					slot_d[i] = dn_src;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance && valid_s1) begin
				slots_q[i] <= slot_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			ok_q    <= op_ok;
			rd_q    <= rd_d;
			cnt_q   <= count_dx[pls_pkg::CNT_W-1:0];
			empty_q <= (count_d == '0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign ok          = ok_q;
	assign read_value  = rd_q;
	assign entry_count = cnt_q;
	assign is_empty    = empty_q;

endmodule

// File: rtl/pls_checker.sv
// Port-level checker for positional_list_store, bound into positional_list_store.
// Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic [pls_pkg::CMD_W-1:0]  cmd,
	input logic [pls_pkg::POS_W-1:0]  position,
	input logic [pls_pkg::VAL_W-1:0]  item_value,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       ok,
	input logic [pls_pkg::VAL_W-1:0]  read_value,
	input logic [pls_pkg::CNT_W-1:0]  entry_count,
	input logic                       is_empty
);

	// A rejected transaction carries zero read data.
	`PLS_ASSERT_IMP(a_rej_zero, clk, arst_n, rsp_valid && !ok, read_value == '0)

	// Backpressure on commands only when a result is held.
	`PLS_ASSERT_IMP(a_stall_src, clk, arst_n, !cmd_ready, rsp_valid && !rsp_ready)

	// A new result rises only after an accepted command has passed the input register.
	`PLS_ASSERT_IMP(a_rsp_cause, clk, arst_n, $rose(rsp_valid),
		$past(cmd_valid && cmd_ready, 2))

	// Stalled result stays put.
	`PLS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(ok) && $stable(read_value) && $stable(entry_count)
		&& $stable(is_empty))

	// A waiting command keeps valid and payload.
	`PLS_ASSERT_NXT(a_cmd_hold, clk, arst_n, cmd_valid && !cmd_ready,
		cmd_valid && $stable(cmd) && $stable(position) && $stable(item_value))

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
